@@ src/tlsfp_pkg.sv @@
// Package for the TLS server flight parser: phases, constants and shared types.
package tlsfp_pkg;

  localparam int unsigned BYTE_COUNT_BITS_DEF = 24;
  localparam logic [15:0] LIMIT_RESET = 16'd18432;
  localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'h002b;
  localparam logic [7:0] CT_ALERT = 8'd21;
  localparam logic [7:0] CT_HANDSHAKE = 8'd22;
  localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
  localparam logic [7:0] HS_CERTIFICATE = 8'd11;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_NO_HS = 2'd2;

  typedef enum logic [4:0] {
    PH_REC_TYPE, PH_REC_VER, PH_REC_LEN, PH_STOP,
    PH_SKIP_REC, PH_ALERT_LEVEL, PH_ALERT_DESC, PH_HS_TYPE, PH_HS_LEN,
    PH_SKIP_MSG, PH_SH_VER, PH_SH_RANDOM, PH_SH_SIDLEN, PH_SH_SID, PH_SH_SUITE,
    PH_SH_EXTLEN, PH_CERT_LISTLEN, PH_CERT_LEN, PH_CERT_BODY,
    PH_EXT_TYPE, PH_EXT_SIZE, PH_EXT_SV, PH_EXT_DATA, PH_EXT_TAIL
  } phase_t;

  // One classified byte as it travels from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_tls;
    logic [15:0] reported_version;
    logic [15:0] suite_id;
    logic        alert_seen;
    logic        alert_fatal;
    logic [7:0]  alert_code;
    logic [15:0] cert_total;
    logic [23:0] byte_total;
  } summary_t;

endpackage

@@ src/tlsfp_front.sv @@
// Front part: accepts bytes and queues them for the parser back part.
module tlsfp_front import tlsfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  byte_req_t in_req,
  output logic      q_valid,
  input  logic      q_ready,
  output byte_req_t q_req
);
  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  byte_req_t      mem_r [FIFO_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign in_ready = (cnt_r != (AW+1)'(FIFO_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ src/tlsfp_back.sv @@
// Back part: the record and handshake parser state machine and summary output register.
module tlsfp_back import tlsfp_pkg::*; #(
  parameter int unsigned BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] limit,
  input  logic        q_valid,
  output logic        q_ready,
  input  byte_req_t   q_req,
  output logic        out_valid,
  input  logic        out_ready,
  output summary_t    out_sum
);
  localparam logic [BYTE_COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t ph_r, ph_nxt;
  logic [23:0] fs_r, fs_nxt;
  logic [1:0]  fi_r, fi_nxt;
  logic [15:0] rl_r, rl_nxt;
  logic        rte_r, rte_nxt;
  logic [23:0] ml_r, ml_nxt;
  logic [15:0] eb_r, eb_nxt, ei_r, ei_nxt;
  logic [16:0] pv_r, pv_nxt;
  logic [23:0] cl_r, cl_nxt, ce_r, ce_nxt;
  logic [15:0] rv_r, rv_nxt, hv_r, hv_nxt, su_r, su_nxt;
  logic [9:0]  al_r, al_nxt;
  logic [2:0]  fl_r, fl_nxt;
  logic [15:0] cc_r, cc_nxt;
  logic [BYTE_COUNT_BITS-1:0] bc_r, bc_nxt;
  logic        ov_r;
  summary_t    os_r, sum_nxt;
  logic        take;

  assign q_ready   = !ov_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_sum   = os_r;

  always_comb begin
    logic [7:0]  b;
    logic [23:0] sh;
    logic [1:0]  idx;
    logic        done2, done3;
    logic [23:0] v;
    logic [23:0] t24;
    phase_t      ph;
    b = q_req.data;
    ph = ph_r;
    ph_nxt = ph_r; fs_nxt = fs_r; fi_nxt = fi_r; rl_nxt = rl_r; rte_nxt = rte_r;
    ml_nxt = ml_r; eb_nxt = eb_r; ei_nxt = ei_r; pv_nxt = pv_r; cl_nxt = cl_r;
    ce_nxt = ce_r; rv_nxt = rv_r; hv_nxt = hv_r; su_nxt = su_r; al_nxt = al_r;
    fl_nxt = fl_r; cc_nxt = cc_r;
    bc_nxt = (bc_r != CNT_MAX) ? bc_r + 1'b1 : bc_r;
    // Field collector: shifted value and completion for 2- and 3-byte fields.
    sh = {fs_r[15:0], b};
    idx = fi_r + 2'd1;
    done2 = (idx >= 2'd2);
    done3 = (idx == 2'd3);
    v = sh;
    t24 = '0;

    if (ph == PH_STOP) begin
    end else if (ph == PH_REC_TYPE) begin
      if (b < 8'd20 || b > 8'd24) ph_nxt = PH_STOP;
      else begin rl_nxt = {8'd0, b}; ph_nxt = PH_REC_VER; end
    end else if (ph == PH_REC_VER) begin
      fs_nxt = sh; fi_nxt = idx;
      if (done2) begin
        fs_nxt = '0; fi_nxt = '0;
        if (rv_r == '0) rv_nxt = v[15:0];
        ph_nxt = PH_REC_LEN;
      end
    end else if (ph == PH_REC_LEN) begin
      fs_nxt = sh; fi_nxt = idx;
      if (done2) begin
        fs_nxt = '0; fi_nxt = '0;
        rte_nxt = (v[15:0] > limit);
        rl_nxt = rte_nxt ? 16'd0 : v[15:0];
        if (rl_r[7:0] == CT_ALERT) ph_nxt = PH_ALERT_LEVEL;
        else if (rl_r[7:0] == CT_HANDSHAKE) begin
          fl_nxt[1] = 1'b1;
          ph_nxt = (!rte_nxt && rl_nxt < 16'd4) ? PH_SKIP_REC : PH_HS_TYPE;
        end else ph_nxt = PH_SKIP_REC;
      end
    end else begin
      if (!rte_r) rl_nxt = rl_r - 1'b1;
      if (ph >= PH_SKIP_MSG) ml_nxt = ml_r - 1'b1;
      if (ph >= PH_EXT_TYPE) eb_nxt = eb_r - 1'b1;
      unique case (ph)
        PH_ALERT_LEVEL: begin
          ei_nxt = {15'd0, b == 8'd2}; ph_nxt = PH_ALERT_DESC;
        end
        PH_ALERT_DESC: begin
          al_nxt = {1'b1, ei_r[0], b}; fl_nxt[0] = 1'b1; ph_nxt = PH_SKIP_REC;
        end
        PH_HS_TYPE: begin ml_nxt = {16'd0, b}; ph_nxt = PH_HS_LEN; end
        PH_HS_LEN: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done3) begin
            fs_nxt = '0; fi_nxt = '0;
            ml_nxt = (!rte_r && v > {8'd0, rl_nxt}) ? {8'd0, rl_nxt} : v;
            if (ml_nxt == '0)
              ph_nxt = (!rte_r && rl_nxt < 16'd4) ? PH_SKIP_REC : PH_HS_TYPE;
            else if (ml_r[7:0] == HS_SERVER_HELLO) ph_nxt = PH_SH_VER;
            else if (ml_r[7:0] == HS_CERTIFICATE) ph_nxt = PH_CERT_LISTLEN;
            else ph_nxt = PH_SKIP_MSG;
          end
        end
        PH_SH_VER: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done2) begin
            fs_nxt = '0; fi_nxt = '0;
            pv_nxt = {1'b0, v[15:0]}; fl_nxt[0] = 1'b1; ei_nxt = 16'd32;
            ph_nxt = PH_SH_RANDOM;
          end
        end
        PH_SH_RANDOM: begin
          ei_nxt = ei_r - 1'b1;
          if (ei_nxt == '0) ph_nxt = PH_SH_SIDLEN;
        end
        PH_SH_SIDLEN: begin
          ei_nxt = {8'd0, b};
          ph_nxt = (b == 8'd0) ? PH_SH_SUITE : PH_SH_SID;
        end
        PH_SH_SID: begin
          ei_nxt = ei_r - 1'b1;
          if (ei_nxt == '0) ph_nxt = PH_SH_SUITE;
        end
        PH_SH_SUITE: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done2) begin
            fs_nxt = '0; fi_nxt = '0;
            hv_nxt = pv_r[15:0]; su_nxt = v[15:0]; fl_nxt[2] = 1'b1; pv_nxt = '0;
            ph_nxt = PH_SH_EXTLEN;
          end
        end
        PH_SH_EXTLEN: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done2) begin
            fs_nxt = '0; fi_nxt = '0;
            if (v[15:0] == '0 || {8'd0, v[15:0]} > ml_nxt) ph_nxt = PH_SKIP_MSG;
            else begin
              eb_nxt = v[15:0];
              ph_nxt = (eb_nxt >= 16'd4) ? PH_EXT_TYPE : PH_EXT_TAIL;
            end
          end
        end
        PH_EXT_TYPE: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done2) begin
            fs_nxt = '0; fi_nxt = '0;
            ei_nxt = {15'd0, v[15:0] == EXT_SUPPORTED_VERSIONS};
            ph_nxt = PH_EXT_SIZE;
          end
        end
        PH_EXT_SIZE: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done2) begin
            fs_nxt = '0; fi_nxt = '0;
            if (v[15:0] == '0 || v[15:0] > eb_nxt)
              ph_nxt = (eb_nxt >= 16'd4) ? PH_EXT_TYPE : PH_EXT_TAIL;
            else begin
              ei_nxt = v[15:0];
              ph_nxt = (ei_r[0] && v[15:0] >= 16'd2) ? PH_EXT_SV : PH_EXT_DATA;
            end
          end
        end
        PH_EXT_SV: begin
          ei_nxt = ei_r - 1'b1;
          fs_nxt = sh; fi_nxt = idx;
          if (done2) begin
            fs_nxt = '0; fi_nxt = '0;
            pv_nxt = {1'b1, v[15:0]};
            if (ei_nxt == '0) ph_nxt = (eb_nxt >= 16'd4) ? PH_EXT_TYPE : PH_EXT_TAIL;
            else ph_nxt = PH_EXT_DATA;
          end
        end
        PH_EXT_DATA: begin
          ei_nxt = ei_r - 1'b1;
          if (ei_nxt == '0) ph_nxt = (eb_nxt >= 16'd4) ? PH_EXT_TYPE : PH_EXT_TAIL;
        end
        PH_CERT_LISTLEN: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done3) begin
            fs_nxt = '0; fi_nxt = '0;
            fl_nxt[0] = 1'b1; cl_nxt = v;
            ph_nxt = (cl_nxt >= 24'd3 && ml_nxt >= 24'd3) ? PH_CERT_LEN : PH_SKIP_MSG;
          end
        end
        PH_CERT_LEN: begin
          fs_nxt = sh; fi_nxt = idx;
          if (done3) begin
            fs_nxt = '0; fi_nxt = '0;
            t24 = cl_r - 24'd3;
            cl_nxt = t24;
            if (v == '0 || v > ml_nxt) ph_nxt = PH_SKIP_MSG;
            else begin
              cl_nxt = (v > t24) ? 24'd0 : t24 - v;
              ce_nxt = v; ph_nxt = PH_CERT_BODY;
            end
          end
        end
        PH_CERT_BODY: begin
          ce_nxt = ce_r - 1'b1;
          if (ce_nxt == '0) begin
            if (cc_r != 16'hFFFF) cc_nxt = cc_r + 1'b1;
            ph_nxt = (cl_r >= 24'd3 && ml_nxt >= 24'd3) ? PH_CERT_LEN : PH_SKIP_MSG;
          end
        end
        default: begin end
      endcase
      if (ph >= PH_EXT_TYPE && eb_nxt == '0) begin
        if (pv_nxt[16]) hv_nxt = pv_nxt[15:0];
        pv_nxt = '0; ph_nxt = PH_SKIP_MSG;
      end
      if (ph >= PH_SKIP_MSG && ml_nxt == '0)
        ph_nxt = (!rte_r && rl_nxt < 16'd4) ? PH_SKIP_REC : PH_HS_TYPE;
    end
    if (ph_nxt >= PH_SKIP_REC && !rte_nxt && rl_nxt == '0) ph_nxt = PH_REC_TYPE;
    if (ph_nxt != ph_r) begin fs_nxt = '0; fi_nxt = '0; end

    sum_nxt = '0;
    if (bc_nxt < BYTE_COUNT_BITS'(5)) sum_nxt.status = ST_TOO_SHORT;
    else if (fl_nxt[1:0] == 2'b00) sum_nxt.status = ST_NO_HS;
    else begin
      sum_nxt.status = ST_OK;
      sum_nxt.is_tls = fl_nxt[0];
      sum_nxt.reported_version = fl_nxt[2] ? hv_nxt : rv_nxt;
      sum_nxt.suite_id = su_nxt;
      sum_nxt.alert_seen = al_nxt[9];
      sum_nxt.alert_fatal = al_nxt[8];
      sum_nxt.alert_code = al_nxt[7:0];
      sum_nxt.cert_total = cc_nxt;
    end
    if (BYTE_COUNT_BITS > 24 && bc_nxt > BYTE_COUNT_BITS'(24'hFFFFFF))
      sum_nxt.byte_total = 24'hFFFFFF;
    else sum_nxt.byte_total = 24'(bc_nxt);
  end

  always_ff @(posedge clk) begin
    if (take && q_req.last) os_r <= sum_nxt;
    if (!rst_n || (take && q_req.last)) begin
      ph_r <= PH_REC_TYPE; fs_r <= '0; fi_r <= '0; rl_r <= '0; rte_r <= 1'b0;
      ml_r <= '0; eb_r <= '0; ei_r <= '0; pv_r <= '0; cl_r <= '0; ce_r <= '0;
      rv_r <= '0; hv_r <= '0; su_r <= '0; al_r <= '0; fl_r <= '0; cc_r <= '0;
      bc_r <= '0;
    end else if (take) begin
      ph_r <= ph_nxt; fs_r <= fs_nxt; fi_r <= fi_nxt; rl_r <= rl_nxt; rte_r <= rte_nxt;
      ml_r <= ml_nxt; eb_r <= eb_nxt; ei_r <= ei_nxt; pv_r <= pv_nxt; cl_r <= cl_nxt;
      ce_r <= ce_nxt; rv_r <= rv_nxt; hv_r <= hv_nxt; su_r <= su_nxt; al_r <= al_nxt;
      fl_r <= fl_nxt; cc_r <= cc_nxt; bc_r <= bc_nxt;
    end
    if (!rst_n) ov_r <= 1'b0;
    else if (take && q_req.last) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end
endmodule

@@ src/tls_server_flight_parser.sv @@
// Top level of the TLS server flight parser: configuration register, front queue, parser.
// The block takes one captured server byte per cycle on the in_ stream while
// in_tready is high and, on the byte marked by in_tlast, delivers one summary
// request on the out_ stream: status, whether TLS was recognized, the negotiated
// version and cipher suite, the latest alert, the count of whole certificates
// and the capture length. A four-entry queue separates the byte intake from the
// parser; the parser retires one byte per cycle through a registered state update
// unless a summary waits with out_tready low. The last byte passes through the
// queue and the parser state update into the summary output register that drives
// out_tvalid. While a summary waits there with out_tready low, the parser holds,
// and the queue takes up to four more bytes before in_tready drops. After a
// summary the parser restarts for a new capture. The user writes record_length_limit
// on the cfg_ channel only while idle; the block does not enforce it.
module tls_server_flight_parser import tlsfp_pkg::*; #(
  parameter int unsigned BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], is_tls[2], reported_version[18:3], suite_id[34:19],
  // alert_seen[35], alert_fatal[36], alert_code[44:37],
  // cert_total[60:45], byte_total[84:61], zero fill to 88 bits
  output logic [87:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data     // record_length_limit
);
  logic [15:0] limit_r;
  logic        q_valid, q_ready;
  byte_req_t   in_req, q_req;
  summary_t    sum;

  // The limit register accepts a write in any cycle.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (cfg_valid) limit_r <= cfg_data;
  end

  assign in_req.data = in_tdata;
  assign in_req.last = in_tlast;

  tlsfp_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  tlsfp_back #(.BYTE_COUNT_BITS(BYTE_COUNT_BITS)) u_back (
    .clk, .rst_n, .limit(limit_r), .q_valid, .q_ready, .q_req,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_sum(sum)
  );

  assign out_tdata = {3'd0, sum.byte_total, sum.cert_total, sum.alert_code,
                      sum.alert_fatal, sum.alert_seen, sum.suite_id,
                      sum.reported_version, sum.is_tls, sum.status};
endmodule

@@ tb/tls_server_flight_parser_tb.sv @@
// Self-checking testbench for the TLS server flight parser with a built-in flight predictor.
`timescale 1ns / 1ps

import tlsfp_pkg::*;

typedef logic [7:0] u8_t;

// Scoreboard: predicts the summary of each capture byte by byte and checks the
// summaries that the block delivers, oldest first.
class flight_scoreboard;
  logic [15:0] rec_len_limit;
  phase_t      phase;
  int unsigned shift_acc, shift_idx, rec_left, runs_end, msg_left;
  int unsigned ext_block, item_left, pend_ver, list_left, cert_left;
  int unsigned rec_ver, hello_ver, suite, alert, flags, certs, nbytes;
  summary_t    summaries[$];
  int          errors;

  function new();
    rec_len_limit = LIMIT_RESET;
    errors = 0;
    restart();
  endfunction

  function void restart();
    phase = PH_REC_TYPE;
    shift_acc = 0; shift_idx = 0; rec_left = 0; runs_end = 0; msg_left = 0;
    ext_block = 0; item_left = 0; pend_ver = 0; list_left = 0; cert_left = 0;
    rec_ver = 0; hello_ver = 0; suite = 0; alert = 0; flags = 0; certs = 0;
    nbytes = 0;
  endfunction

  // Shifts one byte into a multi-byte field; returns 1 when n bytes are in.
  function bit gather(int unsigned b, int unsigned n, output int unsigned v);
    v = 0;
    shift_acc = ((shift_acc << 8) | b) & 32'hFFFFFF;
    shift_idx++;
    if (shift_idx >= n) begin
      v = shift_acc;
      shift_acc = 0;
      shift_idx = 0;
      return 1;
    end
    return 0;
  endfunction

  function void msg_hdr();
    phase = (!runs_end && rec_left < 4) ? PH_SKIP_REC : PH_HS_TYPE;
  endfunction

  function void ext_hdr();
    phase = (ext_block >= 4) ? PH_EXT_TYPE : PH_EXT_TAIL;
  endfunction

  function void cert_hdr();
    phase = (list_left >= 3 && msg_left >= 3) ? PH_CERT_LEN : PH_SKIP_MSG;
  endfunction

  function void body_byte(phase_t ph, int unsigned b);
    int unsigned v, kind, sv;
    case (ph)
      PH_ALERT_LEVEL: begin
        item_left = (b == 2);
        phase = PH_ALERT_DESC;
      end
      PH_ALERT_DESC: begin
        alert = 32'h200 | ((item_left & 1) << 8) | b;
        flags |= 1;
        phase = PH_SKIP_REC;
      end
      PH_HS_TYPE: begin
        msg_left = b;
        phase = PH_HS_LEN;
      end
      PH_HS_LEN: begin
        if (gather(b, 3, v)) begin
          kind = msg_left;
          msg_left = (!runs_end && v > rec_left) ? rec_left : v;
          if (msg_left == 0) msg_hdr();
          else if (kind == HS_SERVER_HELLO) phase = PH_SH_VER;
          else if (kind == HS_CERTIFICATE) phase = PH_CERT_LISTLEN;
          else phase = PH_SKIP_MSG;
        end
      end
      PH_SH_VER: begin
        if (gather(b, 2, v)) begin
          pend_ver = v;
          flags |= 1;
          item_left = 32;
          phase = PH_SH_RANDOM;
        end
      end
      PH_SH_RANDOM: begin
        item_left = (item_left - 1) & 16'hFFFF;
        if (item_left == 0) phase = PH_SH_SIDLEN;
      end
      PH_SH_SIDLEN: begin
        item_left = b;
        phase = (b == 0) ? PH_SH_SUITE : PH_SH_SID;
      end
      PH_SH_SID: begin
        item_left = (item_left - 1) & 16'hFFFF;
        if (item_left == 0) phase = PH_SH_SUITE;
      end
      PH_SH_SUITE: begin
        if (gather(b, 2, v)) begin
          hello_ver = pend_ver & 16'hFFFF;
          suite = v;
          flags |= 4;
          pend_ver = 0;
          phase = PH_SH_EXTLEN;
        end
      end
      PH_SH_EXTLEN: begin
        if (gather(b, 2, v)) begin
          if (v == 0 || v > msg_left) begin
            phase = PH_SKIP_MSG;
          end else begin
            ext_block = v;
            ext_hdr();
          end
        end
      end
      PH_EXT_TYPE: begin
        if (gather(b, 2, v)) begin
          item_left = (v == EXT_SUPPORTED_VERSIONS);
          phase = PH_EXT_SIZE;
        end
      end
      PH_EXT_SIZE: begin
        if (gather(b, 2, v)) begin
          sv = item_left;
          // An extension that overruns its block is treated as empty.
          if (v == 0 || v > ext_block) begin
            ext_hdr();
          end else begin
            item_left = v;
            phase = (sv != 0 && v >= 2) ? PH_EXT_SV : PH_EXT_DATA;
          end
        end
      end
      PH_EXT_SV: begin
        item_left = (item_left - 1) & 16'hFFFF;
        if (gather(b, 2, v)) begin
          pend_ver = 32'h10000 | v;
          if (item_left == 0) ext_hdr();
          else phase = PH_EXT_DATA;
        end
      end
      PH_EXT_DATA: begin
        item_left = (item_left - 1) & 16'hFFFF;
        if (item_left == 0) ext_hdr();
      end
      PH_CERT_LISTLEN: begin
        if (gather(b, 3, v)) begin
          flags |= 1;
          list_left = v;
          cert_hdr();
        end
      end
      PH_CERT_LEN: begin
        if (gather(b, 3, v)) begin
          list_left -= 3;
          if (v == 0 || v > msg_left) begin
            phase = PH_SKIP_MSG;
          end else begin
            list_left = (v > list_left) ? 0 : list_left - v;
            cert_left = v;
            phase = PH_CERT_BODY;
          end
        end
      end
      PH_CERT_BODY: begin
        cert_left = (cert_left - 1) & 32'hFFFFFF;
        if (cert_left == 0) begin
          if (certs < 16'hFFFF) certs++;
          cert_hdr();
        end
      end
      default: ;
    endcase
  endfunction

  function void parse(int unsigned b);
    phase_t      ph;
    int unsigned v, kind;
    ph = phase;
    if (ph == PH_STOP) return;
    if (ph == PH_REC_TYPE) begin
      // Anything outside the TLS content types stops parsing for good.
      if (b < 20 || b > 24) begin
        phase = PH_STOP;
        return;
      end
      rec_left = b;
      phase = PH_REC_VER;
    end else if (ph == PH_REC_VER) begin
      if (gather(b, 2, v)) begin
        if (rec_ver == 0) rec_ver = v;
        phase = PH_REC_LEN;
      end
    end else if (ph == PH_REC_LEN) begin
      if (gather(b, 2, v)) begin
        kind = rec_left;
        runs_end = (v > rec_len_limit);
        rec_left = runs_end ? 0 : v;
        if (kind == CT_ALERT) begin
          phase = PH_ALERT_LEVEL;
        end else if (kind == CT_HANDSHAKE) begin
          flags |= 2;
          msg_hdr();
        end else begin
          phase = PH_SKIP_REC;
        end
      end
    end else begin
      if (!runs_end) rec_left = (rec_left - 1) & 16'hFFFF;
      if (ph >= PH_SKIP_MSG) msg_left = (msg_left - 1) & 32'hFFFFFF;
      if (ph >= PH_EXT_TYPE) ext_block = (ext_block - 1) & 16'hFFFF;
      body_byte(ph, b);
      // The version override is applied only once the whole block has arrived.
      if (ph >= PH_EXT_TYPE && ext_block == 0) begin
        if (pend_ver & 32'h10000) hello_ver = pend_ver & 16'hFFFF;
        pend_ver = 0;
        phase = PH_SKIP_MSG;
      end
      if (ph >= PH_SKIP_MSG && msg_left == 0) msg_hdr();
    end
    if (phase >= PH_SKIP_REC && !runs_end && rec_left == 0) phase = PH_REC_TYPE;
    if (phase != ph) begin
      shift_acc = 0;
      shift_idx = 0;
    end
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    summary_t s;
    if (nbytes < 32'hFFFFFF) nbytes++;
    parse(b);
    if (!last) return;
    s = '0;
    if (nbytes < 5) s.status = ST_TOO_SHORT;
    else if ((flags & 3) == 0) s.status = ST_NO_HS;
    else s.status = ST_OK;
    if (s.status == ST_OK) begin
      s.is_tls           = flags[0];
      s.reported_version = (flags & 4) ? hello_ver[15:0] : rec_ver[15:0];
      s.suite_id         = suite[15:0];
      s.alert_seen       = alert[9];
      s.alert_fatal      = alert[8];
      s.alert_code       = alert[7:0];
      s.cert_total       = certs[15:0];
    end
    s.byte_total = nbytes[23:0];
    summaries = {summaries, s};
    restart();
  endfunction

  function void check_summary(logic [87:0] got);
    summary_t s;
    logic [87:0] want;
    logic [31:0] fw, fg;
    string names[9] = '{"status", "is_tls", "reported_version", "suite_id",
                        "alert_seen", "alert_fatal", "alert_code",
                        "cert_total", "byte_total"};
    int lsb[9] = '{0, 2, 3, 19, 35, 36, 37, 45, 61};
    int wid[9] = '{2, 1, 16, 16, 1, 1, 8, 16, 24};
    if (summaries.size() == 0) begin
      $display("%0t: unexpected summary request %h", $time, got);
      errors++;
      return;
    end
    s = summaries.pop_front();
    want = {3'b0, s.byte_total, s.cert_total, s.alert_code, s.alert_fatal,
            s.alert_seen, s.suite_id, s.reported_version, s.is_tls, s.status};
    for (int i = 0; i < 9; i++) begin
      fw = 32'((want >> lsb[i]) & ((88'd1 << wid[i]) - 1));
      fg = 32'((got >> lsb[i]) & ((88'd1 << wid[i]) - 1));
      if (fw !== fg) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, names[i], fw, fg);
        errors++;
      end
    end
  endfunction
endclass

module tls_server_flight_parser_tb;
  localparam int STALL_LIMIT = 3000;  // cycles without any accepted request
  localparam int SETTLE = 20;         // parser drain time after the last summary

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  flight_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  no_gaps = 0;      // when set, neither side idles
  int  bytes_sent = 0;

  tls_server_flight_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor: every handshake is sampled at the rising edge. A summary accepted
  // in this cycle cannot depend on a byte accepted in the same cycle, so the
  // output check goes first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_summary(out_tdata);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) sb.rec_len_limit = cfg_data;
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result side stalls at random between requests.
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 9) < 3) stall = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_capture(input u8_t cap[$]);
    no_gaps = ($urandom_range(0, 5) == 0);
    foreach (cap[i]) send_byte(cap[i], i == cap.size() - 1);
    bytes_sent += cap.size();
  endtask

  // Holds the sender until every summary is back and the parser has drained.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.summaries.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_limit(input logic [15:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void put8(ref u8_t q[$], input u8_t b);
    q = {q, b};
  endfunction

  function automatic void put16(ref u8_t q[$], input int unsigned v);
    put8(q, v[15:8]);
    put8(q, v[7:0]);
  endfunction

  function automatic void put24(ref u8_t q[$], input int unsigned v);
    put8(q, v[23:16]);
    put16(q, v);
  endfunction

  // Declared lengths are usually exact, sometimes a little off and now and then random.
  function automatic int unsigned skew(input int unsigned n);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, n + 6);
    if (r == 1) return $urandom_range(0, 16'hFFFF);
    return n;
  endfunction

  function automatic void server_hello(ref u8_t q[$]);
    u8_t body[$], exts[$], one[$];
    int  sid, n_ext, dlen;
    bit  sv;
    if ($urandom_range(0, 3) != 0) put16(body, 16'h0303);
    else put16(body, $urandom);
    repeat (32) put8(body, 8'($urandom));
    sid = $urandom_range(0, 4);
    put8(body, 8'(sid));
    repeat (sid) put8(body, 8'($urandom));
    put16(body, $urandom);
    if ($urandom_range(0, 4) != 0) begin
      n_ext = $urandom_range(0, 3);
      repeat (n_ext) begin
        one.delete();
        sv = $urandom_range(0, 1);
        put16(one, sv ? EXT_SUPPORTED_VERSIONS : $urandom_range(0, 16'hFFFF));
        dlen = $urandom_range(0, 6);
        put16(one, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : dlen);
        repeat (dlen) put8(one, 8'($urandom));
        exts = {exts, one};
      end
      put16(body, skew(exts.size()));
      body = {body, exts};
    end
    put8(q, HS_SERVER_HELLO);
    put24(q, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF) : skew(body.size()));
    q = {q, body};
  endfunction

  function automatic void certificate(ref u8_t q[$]);
    u8_t list[$], body[$];
    int  clen;
    repeat ($urandom_range(0, 3)) begin
      clen = $urandom_range(1, 6);
      put24(list, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : clen);
      repeat (clen) put8(list, 8'($urandom));
    end
    put24(body, skew(list.size()));
    body = {body, list};
    put8(q, HS_CERTIFICATE);
    put24(q, skew(body.size()));
    q = {q, body};
  endfunction

  function automatic void record(ref u8_t q[$], input u8_t kind, input u8_t body[$]);
    put8(q, kind);
    if ($urandom_range(0, 4) != 0) put16(q, 16'h0303);
    else put16(q, ($urandom_range(0, 1) != 0) ? 16'h0 : $urandom_range(0, 16'hFFFF));
    put16(q, skew(body.size()));
    q = {q, body};
  endfunction

  // One capture: mostly a well-formed server flight with random content,
  // sometimes short noise, sometimes cut off early.
  function automatic void make_capture(ref u8_t cap[$]);
    u8_t body[$];
    int  k;
    cap.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 7)) put8(cap, 8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      body.delete();
      k = $urandom_range(0, 9);
      if (k < 5) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 3))
            0, 1: server_hello(body);
            2: certificate(body);
            default: begin
              put8(body, 8'($urandom));
              put24(body, 2);
              put16(body, $urandom);
            end
          endcase
        end
        record(cap, CT_HANDSHAKE, body);
      end else if (k < 7) begin
        put8(body, ($urandom_range(0, 1) != 0) ? 8'd2 : 8'($urandom));
        if ($urandom_range(0, 5) != 0) put8(body, 8'($urandom));
        record(cap, CT_ALERT, body);
      end else if (k == 7) begin
        repeat ($urandom_range(0, 6)) put8(body, 8'($urandom));
        record(cap, 8'd23, body);
      end else begin
        repeat ($urandom_range(1, 6)) put8(cap, 8'($urandom));
      end
    end
    if ($urandom_range(0, 4) == 0) cap = cap[0:$urandom_range(0, cap.size() - 1)];
  endfunction

  initial begin
    u8_t cap[$];
    logic [15:0] limits[4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a one-byte capture, a header with no handshake, a fatal alert, a bad
    // content type with every later byte only counted, and a cut-off Certificate record.
    send_capture('{8'd22});
    send_capture('{CT_ALERT, 8'h03, 8'h03, 8'h00, 8'h02});
    send_capture('{CT_ALERT, 8'h03, 8'h03, 8'h00, 8'h02, 8'h02, 8'd40});
    send_capture('{8'h00, 8'hFF, 8'h16, 8'h03, 8'h01, 8'hAA});
    send_capture('{CT_HANDSHAKE, 8'h03, 8'h01, 8'hFF, 8'hFF, HS_CERTIFICATE, 8'h00});

    // Random flights across several record length limits, the extremes among them.
    limits = '{16'd0, 16'hFFFF, 16'd30, LIMIT_RESET};
    for (int phase_no = 0; bytes_sent < 1550; phase_no++) begin
      for (int j = 0; j < 4 && bytes_sent < 1550; j++) begin
        make_capture(cap);
        send_capture(cap);
      end
      set_limit((phase_no % 5 == 4) ? 16'($urandom_range(0, 120)) : limits[phase_no % 4]);
    end

    wait_idle();
    if (sb.errors == 0 && sb.summaries.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ tls_server_flight_parser.f @@
src/tlsfp_pkg.sv
src/tlsfp_front.sv
src/tlsfp_back.sv
src/tls_server_flight_parser.sv
tb/tls_server_flight_parser_tb.sv
